[rtl/dhst_pkg.sv]
package dhst_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [2:0] KIND_QUERY          = 3'd0;
    localparam logic [2:0] KIND_MARK_PROBING   = 3'd1;
    localparam logic [2:0] KIND_MARK_DEAD      = 3'd2;
    localparam logic [2:0] KIND_MARK_NORMAL    = 3'd3;
    localparam logic [2:0] KIND_MARK_CONDEMNED = 3'd4;

    localparam logic [1:0] DS_NORMAL    = 2'd0;
    localparam logic [1:0] DS_PROBING   = 2'd1;
    localparam logic [1:0] DS_DEAD      = 2'd2;
    localparam logic [1:0] DS_CONDEMNED = 2'd3;

    typedef struct packed {
        logic [31:0] dev_id;
        logic [1:0]  dev_state;
        logic [31:0] probe_time;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    function automatic logic kind_is_mark(input logic [2:0] kind);
        logic res;
        case (kind) inside
            KIND_MARK_PROBING, KIND_MARK_DEAD, KIND_MARK_NORMAL, KIND_MARK_CONDEMNED:
                res = 1'b1;
            default:
                res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] kind_target(input logic [2:0] kind);
        logic [1:0] res;
        case (kind)
            KIND_MARK_PROBING:   res = DS_PROBING;
            KIND_MARK_DEAD:      res = DS_DEAD;
            KIND_MARK_CONDEMNED: res = DS_CONDEMNED;
            default:             res = DS_NORMAL;
        endcase
        return res;
    endfunction

endpackage

[rtl/dhst_table.sv]
module dhst_table (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [dhst_pkg::IDX_W-1:0] wr_addr,
    input  dhst_pkg::entry_t         wr_data,
    input  logic                     rd_en,
    input  logic [dhst_pkg::IDX_W-1:0] rd_addr,
    output dhst_pkg::entry_t         rd_data
);

    dhst_pkg::entry_t mem [dhst_pkg::ENTRIES];
    dhst_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/device_health_state_table_top.sv]
// Device health state table. Each item queries or marks one device id; the table is
// scanned in fill order through a single read port and one id comparator, one entry per
// cycle. An item passes through an accept step, a scan of the filled entries that ends
// early on a hit, and an update step that writes the entry and loads the result
// register, held while the previous result waits. s_ready is high only while idle.
// Marks of unknown ids are appended while there is room; once full, such marks are
// dropped and m_overflowed stays set until reset. The table needs no clearing after reset.
module device_health_state_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_dev_id,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_dev_state,
    output logic        m_blacklisted,
    output logic        m_was_tracked,
    output logic        m_dropped,
    output logic [31:0] m_probe_time,
    output logic        m_overflowed
);

    localparam int IDX_W = dhst_pkg::IDX_W;
    localparam int CNT_W = dhst_pkg::CNT_W;

    dhst_pkg::state_t state_reg, state_next;

    logic [2:0]       kind_reg;
    logic [31:0]      dev_reg;
    logic [31:0]      now_reg;
    logic [CNT_W-1:0] count_reg;
    logic             overflow_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    dhst_pkg::entry_t hit_entry_reg;

    logic             m_valid_reg;
    logic [1:0]       m_state_reg;
    logic             m_tracked_reg;
    logic             m_dropped_reg;
    logic [31:0]      m_time_reg;
    logic             m_ovf_reg;

    logic             rd_en;
    dhst_pkg::entry_t rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    dhst_pkg::entry_t wr_data;

    logic issue;
    logic hit;
    logic out_free;
    logic accept;

    logic             is_mark;
    logic [1:0]       target;
    logic             has_room;
    logic             need_write;
    logic             append;
    logic             drop;
    logic [1:0]       res_state;
    logic [31:0]      res_time;

    dhst_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign issue    = scan_reg < count_reg;
    assign hit      = pend_reg && (rd_data.dev_id == dev_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dhst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = dhst_pkg::ST_SCAN;
                end
            end
            dhst_pkg::ST_SCAN: begin
                if (hit || (!issue && !pend_reg)) begin
                    state_next = dhst_pkg::ST_DECIDE;
                end
            end
            dhst_pkg::ST_DECIDE: begin
                if (out_free) begin
                    state_next = dhst_pkg::ST_IDLE;
                end
            end
            default: state_next = dhst_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        unique case (state_reg)
            dhst_pkg::ST_IDLE:   s_ready = 1'b1;
            dhst_pkg::ST_SCAN:   rd_en   = issue;
            dhst_pkg::ST_DECIDE: wr_en   = out_free && need_write;
            default: ;
        endcase
    end

    // update of the entry and the result
    always_comb begin
        is_mark    = dhst_pkg::kind_is_mark(kind_reg);
        target     = dhst_pkg::kind_target(kind_reg);
        has_room   = count_reg < CNT_W'(dhst_pkg::ENTRIES);
        append     = 1'b0;
        drop       = 1'b0;
        need_write = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_data    = hit_entry_reg;
        res_state  = dhst_pkg::DS_NORMAL;
        res_time   = 32'd0;
        if (found_reg) begin
            if (is_mark && !(target == dhst_pkg::DS_PROBING &&
                             hit_entry_reg.dev_state == dhst_pkg::DS_DEAD)) begin
                need_write        = 1'b1;
                wr_data.dev_state = target;
                if (target == dhst_pkg::DS_PROBING) begin
                    wr_data.probe_time = now_reg;
                end
            end
            res_state = wr_data.dev_state;
            res_time  = wr_data.probe_time;
        end else if (is_mark && has_room) begin
            append             = 1'b1;
            need_write         = 1'b1;
            wr_addr            = count_reg[IDX_W-1:0];
            wr_data.dev_id     = dev_reg;
            wr_data.dev_state  = target;
            wr_data.probe_time = (target == dhst_pkg::DS_PROBING) ? now_reg : 32'd0;
            res_state          = target;
            res_time           = wr_data.probe_time;
        end else if (is_mark) begin
            drop = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dhst_pkg::ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == dhst_pkg::ST_SCAN) begin
                pend_reg <= issue && !hit;
            end else begin
                pend_reg <= 1'b0;
            end
            if (state_reg == dhst_pkg::ST_DECIDE && out_free) begin
                m_valid_reg <= 1'b1;
                if (append) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (drop) begin
                    overflow_reg <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            dev_reg   <= s_dev_id;
            now_reg   <= s_now;
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (state_reg == dhst_pkg::ST_SCAN) begin
            if (issue) begin
                scan_reg <= scan_reg + CNT_W'(1);
                pidx_reg <= scan_reg[IDX_W-1:0];
            end
            if (hit) begin
                found_reg     <= 1'b1;
                hit_idx_reg   <= pidx_reg;
                hit_entry_reg <= rd_data;
            end
        end
        if (state_reg == dhst_pkg::ST_DECIDE && out_free) begin
            m_state_reg   <= res_state;
            m_tracked_reg <= found_reg;
            m_dropped_reg <= drop;
            m_time_reg    <= res_time;
            m_ovf_reg     <= overflow_reg || drop;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_dev_state   = m_state_reg;
    assign m_blacklisted = (m_state_reg == dhst_pkg::DS_DEAD) ||
                           (m_state_reg == dhst_pkg::DS_CONDEMNED);
    assign m_was_tracked = m_tracked_reg;
    assign m_dropped     = m_dropped_reg;
    assign m_probe_time  = m_time_reg;
    assign m_overflowed  = m_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(dhst_pkg::ENTRIES))
        else $error("entry count beyond table size");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    a_write_in_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == dhst_pkg::ST_DECIDE)
        else $error("table write outside update");

    a_drop_sets_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |-> m_overflowed)
        else $error("dropped item without overflow flag");

    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_reg && !rd_en)
        else $error("table read while idle");
`endif

endmodule
